>>> sv/deadline_ordered_task_queue_assert.svh
// Assertion macros for the task queue.
// Each macro takes a label, the clock, the reset and the expressions to check.
`ifndef DEADLINE_ORDERED_TASK_QUEUE_ASSERT_SVH
`define DEADLINE_ORDERED_TASK_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// The expression holds at every clock edge outside reset.
`define DOTQ_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("task queue assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define DOTQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("task queue assertion failed");

// The consequent holds in the cycle after the antecedent.
`define DOTQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("task queue assertion failed");

`else

`define DOTQ_ASSERT_ALWAYS(label, clk, rst, expr)
`define DOTQ_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DOTQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/dotq_pkg.sv
package dotq_pkg;

   // Default sizes of the queue and of the saturating counters.
   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // Fixed field widths.
   localparam int ID_WIDTH     = 32;
   localparam int OWNER_WIDTH  = 8;
   localparam int TICK_WIDTH   = 32;
   localparam int STATUS_WIDTH = 3;

   // Request kinds.
   typedef enum logic {
      REQ_CREATE = 1'b0,
      REQ_FINISH = 1'b1
   } req_kind_type;

   // Result status codes.
   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_QUEUED   = 3'd0,
      STATUS_REJECTED = 3'd1,
      STATUS_DROPPED  = 3'd2,
      STATUS_ON_TIME  = 3'd3,
      STATUS_LATE     = 3'd4,
      STATUS_EMPTY    = 3'd5
   } status_type;

   // One request as it arrives on the input channel.
   typedef struct packed {
      logic                   req_type;
      logic [ID_WIDTH-1:0]    task_id;
      logic [OWNER_WIDTH-1:0] owner;
      logic [TICK_WIDTH-1:0]  deadline;
      logic [TICK_WIDTH-1:0]  period;
      logic [TICK_WIDTH-1:0]  now;
   } req_payload_type;

   // One entry of the sorted task queue.
   typedef struct packed {
      logic [ID_WIDTH-1:0]    id;
      logic [OWNER_WIDTH-1:0] owner;
      logic [TICK_WIDTH-1:0]  deadline;
   } slot_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic evaluate;
      logic commit;
      logic report;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

>>> sv/dotq_if.sv
// Request channel: one create or finish request per transfer.
interface dotq_req_if;
   import dotq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   req_type;
   logic [ID_WIDTH-1:0]    task_id;
   logic [OWNER_WIDTH-1:0] owner;
   logic [TICK_WIDTH-1:0]  deadline;
   logic [TICK_WIDTH-1:0]  period;
   logic [TICK_WIDTH-1:0]  now;

   modport source (
      output valid, req_type, task_id, owner, deadline, period, now,
      input  ready
   );

   modport sink (
      input  valid, req_type, task_id, owner, deadline, period, now,
      output ready
   );
endinterface

// Result channel: one result per request.
interface dotq_rsp_if #(
   parameter int QUEUE_DEPTH = dotq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int COUNT_WIDTH = dotq_pkg::COUNT_WIDTH_DEFAULT
);
   import dotq_pkg::*;

   localparam int FILL_WIDTH = $clog2(QUEUE_DEPTH + 1);

   logic                    valid;
   logic                    ready;
   logic [STATUS_WIDTH-1:0] status;
   logic [ID_WIDTH-1:0]     finished_id;
   logic                    head_valid;
   logic [ID_WIDTH-1:0]     head_id;
   logic [OWNER_WIDTH-1:0]  head_owner;
   logic [TICK_WIDTH-1:0]   head_deadline;
   logic [FILL_WIDTH-1:0]   active_count;
   logic [COUNT_WIDTH-1:0]  done_count;
   logic [COUNT_WIDTH-1:0]  late_count;

   modport source (
      output valid, status, finished_id, head_valid, head_id, head_owner,
             head_deadline, active_count, done_count, late_count,
      input  ready
   );

   modport sink (
      input  valid, status, finished_id, head_valid, head_id, head_owner,
             head_deadline, active_count, done_count, late_count,
      output ready
   );
endinterface

>>> sv/dotq_controller.sv
module dotq_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output dotq_pkg::ctrl_cmd_type  cmd,
   input  dotq_pkg::dp_status_type dp_status
);
   import dotq_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_COMMIT = 4'b0100,
      ST_REPORT = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // A request is taken only while no other request is in flight.
   assign req_ready = (state_ff == ST_IDLE);

   // Sequence each request through check, commit and report.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.evaluate = 1'b1;
            state_in     = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_REPORT;
         end
         ST_REPORT: begin
            if (dp_status.out_free) begin
               cmd.report = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/dotq_datapath.sv
module dotq_datapath #(
   parameter int QUEUE_DEPTH = dotq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int COUNT_WIDTH = dotq_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dotq_pkg::ctrl_cmd_type              cmd,
   output dotq_pkg::dp_status_type             dp_status,
   input  dotq_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output dotq_pkg::status_type                rsp_status,
   output logic [dotq_pkg::ID_WIDTH-1:0]       rsp_finished_id,
   output logic                                rsp_head_valid,
   output logic [dotq_pkg::ID_WIDTH-1:0]       rsp_head_id,
   output logic [dotq_pkg::OWNER_WIDTH-1:0]    rsp_head_owner,
   output logic [dotq_pkg::TICK_WIDTH-1:0]     rsp_head_deadline,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]    rsp_active_count,
   output logic [COUNT_WIDTH-1:0]              rsp_done_count,
   output logic [COUNT_WIDTH-1:0]              rsp_late_count
);
   import dotq_pkg::*;

   localparam int                    FILL_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [FILL_WIDTH-1:0] FILL_FULL  = FILL_WIDTH'(QUEUE_DEPTH);

   // Request register and per-request decision.
   req_payload_type         req_ff;
   status_type              status_ff;
   status_type              status_in;
   logic [ID_WIDTH-1:0]     fin_id_ff;
   logic [ID_WIDTH-1:0]     fin_id_in;
   logic [QUEUE_DEPTH-1:0]  le_ff;
   logic [QUEUE_DEPTH-1:0]  le_in;
   logic [QUEUE_DEPTH-1:0]  prev_le;

   // Sorted task cells, earliest deadline in cell zero.
   slot_type                cell_ff [QUEUE_DEPTH];
   slot_type                new_slot;

   // Fill level and saturating counters.
   logic [FILL_WIDTH-1:0]   fill_ff;
   logic [FILL_WIDTH-1:0]   fill_in;
   logic [COUNT_WIDTH-1:0]  done_ff;
   logic [COUNT_WIDTH-1:0]  done_in;
   logic [COUNT_WIDTH-1:0]  late_ff;
   logic [COUNT_WIDTH-1:0]  late_in;

   // Output register.
   logic                    out_valid_ff;
   logic                    out_valid_in;
   status_type              out_status_ff;
   logic [ID_WIDTH-1:0]     out_fin_id_ff;
   logic                    out_head_valid_ff;
   slot_type                out_head_ff;
   logic [FILL_WIDTH-1:0]   out_fill_ff;
   logic [COUNT_WIDTH-1:0]  out_done_ff;
   logic [COUNT_WIDTH-1:0]  out_late_ff;

   // Admission and completion checks.
   logic [TICK_WIDTH:0]     admit_sum;
   logic                    overdue;
   logic                    queue_full;
   logic                    queue_empty;
   logic                    before_deadline;

   assign admit_sum       = {1'b0, req_ff.now} + {1'b0, req_ff.period};
   assign overdue         = {1'b0, req_ff.deadline} > admit_sum;
   assign queue_full      = (fill_ff == FILL_FULL);
   assign queue_empty     = (fill_ff == '0);
   assign before_deadline = req_ff.now < cell_ff[0].deadline;

   assign new_slot = '{id: req_ff.task_id, owner: req_ff.owner, deadline: req_ff.deadline};

   // The cell in front of cell zero always counts as at or before the new deadline.
   assign prev_le = {le_ff[QUEUE_DEPTH-2:0], 1'b1};

   // Decide the outcome of the request.
   always_comb begin
      status_in = status_ff;
      fin_id_in = fin_id_ff;
      if (cmd.evaluate) begin
         fin_id_in = '0;
         if (req_ff.req_type == REQ_CREATE) begin
            if (overdue) begin
               status_in = STATUS_REJECTED;
            end else if (queue_full) begin
               status_in = STATUS_DROPPED;
            end else begin
               status_in = STATUS_QUEUED;
            end
         end else begin
            if (queue_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               fin_id_in = cell_ff[0].id;
               status_in = before_deadline ? STATUS_ON_TIME : STATUS_LATE;
            end
         end
      end
   end

   // Each cell compares its own deadline and shifts on commit.
   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      slot_type up_slot;
      slot_type down_slot;
      slot_type slot_in;

      if (k == 0) begin : g_first
         assign up_slot = new_slot;
      end else begin : g_rest
         assign up_slot = cell_ff[k-1];
      end

      if (k == QUEUE_DEPTH - 1) begin : g_last
         assign down_slot = cell_ff[k];
      end else begin : g_inner
         assign down_slot = cell_ff[k+1];
      end

      assign le_in[k] = (FILL_WIDTH'(k) < fill_ff) && (cell_ff[k].deadline <= req_ff.deadline);

      always_comb begin
         slot_in = cell_ff[k];
         if (cmd.commit) begin
            case (status_ff) inside
               STATUS_QUEUED: begin
                  if (!le_ff[k]) begin
                     slot_in = prev_le[k] ? new_slot : up_slot;
                  end
               end
               STATUS_ON_TIME, STATUS_LATE: begin
                  slot_in = down_slot;
               end
               default: begin
                  slot_in = cell_ff[k];
               end
            endcase
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[k] <= slot_in;
      end
   end

   // Fill level and counters change on commit.
   always_comb begin
      fill_in = fill_ff;
      done_in = done_ff;
      late_in = late_ff;
      if (cmd.commit) begin
         case (status_ff) inside
            STATUS_QUEUED: begin
               fill_in = fill_ff + 1'b1;
            end
            STATUS_ON_TIME: begin
               fill_in = fill_ff - 1'b1;
               if (done_ff != '1) begin
                  done_in = done_ff + 1'b1;
               end
            end
            STATUS_LATE: begin
               fill_in = fill_ff - 1'b1;
               if (late_ff != '1) begin
                  late_in = late_ff + 1'b1;
               end
            end
            STATUS_REJECTED: begin
               if (late_ff != '1) begin
                  late_in = late_ff + 1'b1;
               end
            end
            default: begin
               fill_in = fill_ff;
            end
         endcase
      end
   end

   // The output register is free when empty or when its result leaves now.
   assign dp_status.out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.report) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         done_ff      <= '0;
         late_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         done_ff      <= done_in;
         late_ff      <= late_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
      if (cmd.evaluate) begin
         le_ff <= le_in;
      end
      status_ff <= status_in;
      fin_id_ff <= fin_id_in;
      if (cmd.report) begin
         out_status_ff     <= status_ff;
         out_fin_id_ff     <= fin_id_ff;
         out_head_valid_ff <= !queue_empty;
         out_head_ff       <= queue_empty ? slot_type'('0) : cell_ff[0];
         out_fill_ff       <= fill_ff;
         out_done_ff       <= done_ff;
         out_late_ff       <= late_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_finished_id   = out_fin_id_ff;
   assign rsp_head_valid    = out_head_valid_ff;
   assign rsp_head_id       = out_head_ff.id;
   assign rsp_head_owner    = out_head_ff.owner;
   assign rsp_head_deadline = out_head_ff.deadline;
   assign rsp_active_count  = out_fill_ff;
   assign rsp_done_count    = out_done_ff;
   assign rsp_late_count    = out_late_ff;

endmodule

>>> sv/deadline_ordered_task_queue.sv
// Channel   Direction  Transfer
// req_ch    in         one create or finish request
// rsp_ch    out        one result: status, head task and counts
//
// A request is captured at its transfer, checked in the next cycle, committed
// into the sorted cells in the cycle after, and then reported into the output
// register as soon as that register is free. The next request is taken in
// the cycle after the report, so only one request is in flight at a time.
// Reset clears the fill level, the counters and the output valid flag; the
// task cells are not cleared and no clearing pass runs.
// A stalled result holds the report step until the output register frees up.
// While a result waits, one more request can be taken and carried up to its
// report step; the input then stays closed until the waiting result leaves.
`include "deadline_ordered_task_queue_assert.svh"

module deadline_ordered_task_queue #(
   parameter int QUEUE_DEPTH = dotq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int COUNT_WIDTH = dotq_pkg::COUNT_WIDTH_DEFAULT
) (
   input logic     clock,
   input logic     reset,
   dotq_req_if.sink   req_ch,
   dotq_rsp_if.source rsp_ch
);
   import dotq_pkg::*;

   ctrl_cmd_type    cmd;
   dp_status_type   dp_status;
   req_payload_type req_payload;
   status_type      rsp_status;

   // Gather the request fields.
   assign req_payload = '{
      req_type: req_ch.req_type,
      task_id:  req_ch.task_id,
      owner:    req_ch.owner,
      deadline: req_ch.deadline,
      period:   req_ch.period,
      now:      req_ch.now
   };

   dotq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .dp_status (dp_status)
   );

   dotq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .dp_status         (dp_status),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_status        (rsp_status),
      .rsp_finished_id   (rsp_ch.finished_id),
      .rsp_head_valid    (rsp_ch.head_valid),
      .rsp_head_id       (rsp_ch.head_id),
      .rsp_head_owner    (rsp_ch.head_owner),
      .rsp_head_deadline (rsp_ch.head_deadline),
      .rsp_active_count  (rsp_ch.active_count),
      .rsp_done_count    (rsp_ch.done_count),
      .rsp_late_count    (rsp_ch.late_count)
   );

   assign rsp_ch.status = rsp_status;

   // A transfer on the request side starts the check in the next cycle.
   `DOTQ_ASSERT_NEXT(a_accept_starts_check, clock, reset, req_ch.valid && req_ch.ready, cmd.evaluate)

   // Only one request is in flight at a time.
   `DOTQ_ASSERT_NEXT(a_one_in_flight, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)

   // A result is never written over one that has not been taken.
   `DOTQ_ASSERT_IMPLY(a_report_needs_room, clock, reset, cmd.report, dp_status.out_free)

   // The head flag agrees with the reported fill level.
   `DOTQ_ASSERT_IMPLY(a_head_matches_fill, clock, reset, rsp_ch.valid, rsp_ch.head_valid == (rsp_ch.active_count != '0))

endmodule

>>> tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dotq_pkg::*;

   localparam int DEPTH        = QUEUE_DEPTH_DEFAULT;
   localparam int CNT_W        = COUNT_WIDTH_DEFAULT;
   localparam int FILL_W       = $clog2(DEPTH + 1);
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_PCT     = 32;

   // One result as the block reports it.
   typedef struct packed {
      status_type              status;
      logic [ID_WIDTH-1:0]     finished_id;
      logic                    head_valid;
      logic [ID_WIDTH-1:0]     head_id;
      logic [OWNER_WIDTH-1:0]  head_owner;
      logic [TICK_WIDTH-1:0]   head_deadline;
      logic [FILL_W-1:0]       active_count;
      logic [CNT_W-1:0]        done_count;
      logic [CNT_W-1:0]        late_count;
   } task_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dotq_req_if req_ch ();
   dotq_rsp_if #(.QUEUE_DEPTH(DEPTH), .COUNT_WIDTH(CNT_W)) rsp_ch ();

   deadline_ordered_task_queue #(
      .QUEUE_DEPTH (DEPTH),
      .COUNT_WIDTH (CNT_W)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // Requests waiting to be offered, and results still owed by the block.
   req_payload_type pending_reqs[$];
   task_result_type expected_results[$];
   req_payload_type offered_req;

   // Shadow copy of the sorted task list and the saturating tallies.
   logic [TICK_WIDTH-1:0]  sched_deadline [DEPTH];
   logic [ID_WIDTH-1:0]    sched_id       [DEPTH];
   logic [OWNER_WIDTH-1:0] sched_owner    [DEPTH];
   int                     sched_fill     = 0;
   logic [CNT_W-1:0]       on_time_tally  = '0;
   logic [CNT_W-1:0]       late_tally     = '0;

   // Traffic shaping and bookkeeping.
   int                    src_idle_pct = IDLE_PCT;
   int                    snk_idle_pct = IDLE_PCT;
   logic                  hold_request = 1'b0;
   int                    hold_left    = 0;
   logic [TICK_WIDTH-1:0] tick         = '0;
   int                    accepted_reqs = 0;
   int                    results_seen  = 0;
   int                    mismatches    = 0;
   int                    peak_fill     = 0;
   int                    status_tally [6];
   task_result_type       want;

   // Works out the result of one accepted request and advances the shadow state.
   function automatic void schedule_request(input req_payload_type r);
      logic [TICK_WIDTH:0] admit_limit;
      int                  pos;
      int                  k;
      task_result_type     res;
      res = '0;
      if (r.req_type == REQ_CREATE) begin
         // The admission sum is kept one bit wider so that it cannot wrap.
         admit_limit = {1'b0, r.now} + {1'b0, r.period};
         if ({1'b0, r.deadline} > admit_limit) begin
            res.status = STATUS_REJECTED;
            if (late_tally != '1) late_tally++;
         end else if (sched_fill >= DEPTH) begin
            res.status = STATUS_DROPPED;
         end else begin
            // Equal deadlines go behind the ones already queued.
            pos = 0;
            while (pos < sched_fill && sched_deadline[pos] <= r.deadline) pos++;
            for (k = sched_fill; k > pos; k--) begin
               sched_deadline[k] = sched_deadline[k-1];
               sched_id[k]       = sched_id[k-1];
               sched_owner[k]    = sched_owner[k-1];
            end
            sched_deadline[pos] = r.deadline;
            sched_id[pos]       = r.task_id;
            sched_owner[pos]    = r.owner;
            sched_fill++;
            res.status = STATUS_QUEUED;
         end
      end else if (sched_fill == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         res.finished_id = sched_id[0];
         if (r.now < sched_deadline[0]) begin
            res.status = STATUS_ON_TIME;
            if (on_time_tally != '1) on_time_tally++;
         end else begin
            res.status = STATUS_LATE;
            if (late_tally != '1) late_tally++;
         end
         for (k = 0; k + 1 < sched_fill; k++) begin
            sched_deadline[k] = sched_deadline[k+1];
            sched_id[k]       = sched_id[k+1];
            sched_owner[k]    = sched_owner[k+1];
         end
         sched_fill--;
      end
      if (sched_fill > 0) begin
         res.head_valid    = 1'b1;
         res.head_id       = sched_id[0];
         res.head_owner    = sched_owner[0];
         res.head_deadline = sched_deadline[0];
      end
      res.active_count = FILL_W'(sched_fill);
      res.done_count   = on_time_tally;
      res.late_count   = late_tally;
      expected_results.push_back(res);
      status_tally[res.status]++;
      if (sched_fill > peak_fill) peak_fill = sched_fill;
   endfunction

   function automatic void queue_req(input req_kind_type kind,
                                     input logic [ID_WIDTH-1:0] id,
                                     input logic [OWNER_WIDTH-1:0] own,
                                     input logic [TICK_WIDTH-1:0] dl,
                                     input logic [TICK_WIDTH-1:0] per,
                                     input logic [TICK_WIDTH-1:0] nw);
      req_payload_type r;
      r.req_type = kind;
      r.task_id  = id;
      r.owner    = own;
      r.deadline = dl;
      r.period   = per;
      r.now      = nw;
      pending_reqs.push_back(r);
   endfunction

   // Mostly well-formed traffic around a running tick, with a little noise.
   function automatic req_payload_type random_request(input int create_pct);
      req_payload_type r;
      int              roll;
      r = '0;
      tick += $urandom_range(0, 3);
      r.task_id = $urandom;
      r.owner   = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         r.req_type = 1'($urandom_range(0, 1));
         r.deadline = $urandom;
         r.period   = $urandom;
         r.now      = $urandom;
      end else if (roll < create_pct) begin
         r.req_type = REQ_CREATE;
         r.now      = tick;
         if ($urandom_range(0, 99) < 15) begin
            // Deadline beyond the admission window.
            r.period   = $urandom_range(0, 100);
            r.deadline = tick + r.period + 1 + $urandom_range(0, 15);
         end else begin
            r.deadline = tick + $urandom_range(0, 15);
            if ($urandom_range(0, 9) == 0) r.period = $urandom;
            else r.period = (r.deadline - tick) + $urandom_range(0, 3);
         end
      end else begin
         // Finish close to the head deadlines, so both outcomes occur.
         r.req_type = REQ_FINISH;
         r.now      = tick + $urandom_range(0, 20) - 6;
         r.deadline = $urandom;
         r.period   = $urandom;
      end
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || expected_results.size() != 0 || req_ch.valid)
         @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         mismatches++;
         $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      end
   endtask

   // Known values on every input from time zero.
   initial begin
      req_ch.valid    = 1'b0;
      req_ch.req_type = REQ_CREATE;
      req_ch.task_id  = '0;
      req_ch.owner    = '0;
      req_ch.deadline = '0;
      req_ch.period   = '0;
      req_ch.now      = '0;
      rsp_ch.ready    = 1'b0;
      foreach (status_tally[i]) status_tally[i] = 0;
   end

   // Request driver: predicts each transfer, then offers the next request.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            schedule_request(offered_req);
            accepted_reqs++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
               offered_req = pending_reqs.pop_front();
               req_ch.valid    <= 1'b1;
               req_ch.req_type <= offered_req.req_type;
               req_ch.task_id  <= offered_req.task_id;
               req_ch.owner    <= offered_req.owner;
               req_ch.deadline <= offered_req.deadline;
               req_ch.period   <= offered_req.period;
               req_ch.now      <= offered_req.now;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each transfer and paces the ready signal.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               mismatches++;
               $error("result transfer with no expected result pending");
            end else begin
               want = expected_results.pop_front();
               check_field("status", want.status, rsp_ch.status);
               check_field("finished_id", want.finished_id, rsp_ch.finished_id);
               check_field("head_valid", want.head_valid, rsp_ch.head_valid);
               check_field("head_id", want.head_id, rsp_ch.head_id);
               check_field("head_owner", want.head_owner, rsp_ch.head_owner);
               check_field("head_deadline", want.head_deadline, rsp_ch.head_deadline);
               check_field("active_count", want.active_count, rsp_ch.active_count);
               check_field("done_count", want.done_count, rsp_ch.done_count);
               check_field("late_count", want.late_count, rsp_ch.late_count);
            end
         end
         // A long hold-off lets the block fill up and stall its input.
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
         end
      end
   end

   // Stimulus sequence and end of run.
   initial begin
      int chunk;
      int n;
      int create_mix [4];
      create_mix = '{30, 55, 75, 90};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: empty finish, admission edges, ties, full queue.
      queue_req(REQ_FINISH, '1, '1, '1, '1, '1);
      queue_req(REQ_CREATE, '1, '1, '1, '1, '1);
      queue_req(REQ_CREATE, 32'd1, 8'd1, 32'd150, 32'd50, 32'd100);
      queue_req(REQ_CREATE, 32'd2, 8'd2, 32'd151, 32'd50, 32'd100);
      queue_req(REQ_CREATE, '0, '0, '0, '0, '0);
      queue_req(REQ_CREATE, 32'd3, 8'd3, 32'd150, 32'd200, 32'd0);
      queue_req(REQ_CREATE, 32'd4, 8'd4, 32'd150, 32'd200, 32'd0);
      for (n = 0; n < DEPTH - 5; n++)
         queue_req(REQ_CREATE, 32'hA000_0000 + n, 8'(n), 32'd200 + n, 32'h8000_0000, '0);
      queue_req(REQ_CREATE, 32'd5, 8'd5, 32'd300, 32'd1000, 32'd0);
      queue_req(REQ_CREATE, 32'd6, 8'd6, 32'd2000, 32'd10, 32'd0);
      queue_req(REQ_FINISH, $urandom, 8'd0, '0, '0, 32'd0);
      queue_req(REQ_FINISH, $urandom, 8'd0, '0, '0, 32'd149);
      queue_req(REQ_FINISH, $urandom, 8'd0, '0, '0, 32'd150);
      wait_drained();

      // Random part, in chunks with different create/finish mixes.
      tick = $urandom;
      for (chunk = 0; chunk < 10; chunk++) begin
         src_idle_pct = (chunk == 3 || chunk == 4) ? 0 : IDLE_PCT;
         snk_idle_pct = (chunk == 3 || chunk == 4) ? 0 : IDLE_PCT;
         if (chunk == 6) begin
            src_idle_pct = 0;
            hold_request = 1'b1;
         end
         if (chunk == 7) tick = 32'hFFFF_FF00;
         for (n = 0; n < 100; n++)
            pending_reqs.push_back(random_request(create_mix[chunk % 4]));
         wait_drained();
         while (hold_left != 0 || hold_request) @(negedge clock);
      end

      // Drain the queue at full rate, then finish a task exactly at its deadline.
      src_idle_pct = 0;
      snk_idle_pct = 0;
      for (n = 0; n < DEPTH; n++)
         queue_req(REQ_FINISH, $urandom, '0, '0, '0, '0);
      tick = 32'h0001_0000;
      queue_req(REQ_CREATE, 32'd7, 8'd7, tick + 1, 32'd1, tick);
      queue_req(REQ_FINISH, '0, '0, '0, '0, tick + 1);
      wait_drained();
      repeat (8) @(negedge clock);

      if (expected_results.size() != 0) begin
         mismatches++;
         $error("%0d expected results never arrived", expected_results.size());
      end
      $display("Run covered %0d requests: %0d queued, %0d rejected, %0d dropped,",
               accepted_reqs, status_tally[STATUS_QUEUED], status_tally[STATUS_REJECTED],
               status_tally[STATUS_DROPPED]);
      $display("%0d on time, %0d late, %0d on empty; deepest fill %0d of %0d.",
               status_tally[STATUS_ON_TIME], status_tally[STATUS_LATE],
               status_tally[STATUS_EMPTY], peak_fill, DEPTH);
      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #100_000_000;
      $display("Timeout with %0d results still expected", expected_results.size());
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

>>> files.f
+incdir+sv
sv/dotq_pkg.sv
sv/dotq_if.sv
sv/dotq_controller.sv
sv/dotq_datapath.sv
sv/deadline_ordered_task_queue.sv
tb/tb_top.sv
